FILE: src/rdnl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdnl_pkg
// Shared types and register indexes for the relative distance lookup.
// ----------------------------------------------------------------------------
package rdnl_pkg;

    localparam int unsigned CFG_INDEX_WIDTH = 1;
    localparam int unsigned CFG_DATA_WIDTH  = 11;

    // The table depth is tied to the 10-bit slot fields of the channels.
    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned INDEX_WIDTH = $clog2(TABLE_DEPTH);
    localparam int unsigned COUNT_WIDTH = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ENTRY_COUNT    = 1'b0,
        REG_USE_FOURTH_KEY = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

endpackage

FILE: src/rdnl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdnl_in_if / rdnl_out_if / rdnl_cfg_if
// Valid/ready channels of the relative distance lookup.
// ----------------------------------------------------------------------------
interface rdnl_in_if #(parameter int KW = 32, parameter int IW = 10);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [IW-1:0]        entry_index;
    logic signed [KW-1:0] key_first;
    logic signed [KW-1:0] key_second;
    logic signed [KW-1:0] key_third;
    logic signed [KW-1:0] key_fourth;
    logic signed [31:0]   entry_value;
    modport source (output valid, mode, entry_index, key_first, key_second,
                    key_third, key_fourth, entry_value, input ready);
    modport sink (input valid, mode, entry_index, key_first, key_second,
                  key_third, key_fourth, entry_value, output ready);
endinterface

interface rdnl_out_if #(parameter int IW = 10);
    logic               valid;
    logic               ready;
    logic signed [31:0] found_value;
    logic [IW-1:0]      found_index;
    logic               table_empty;
    modport source (output valid, found_value, found_index, table_empty, input ready);
    modport sink (input valid, found_value, found_index, table_empty, output ready);
endinterface

interface rdnl_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/rdnl_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdnl_divider
// Restoring divider, one quotient bit per cycle: floor((num << F) / den).
// ----------------------------------------------------------------------------
module rdnl_divider #(
    parameter int KEY_WIDTH     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [KEY_WIDTH:0]       num,
    input  logic [KEY_WIDTH:0]       den,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quot
);
    // num <= den, so the quotient fits in FRACTION_BITS+1 bits.
    localparam int NW = KEY_WIDTH + 1;
    localparam int CW = $clog2(FRACTION_BITS + 2);

    logic [NW:0]            rem_reg, rem_next;
    logic [NW-1:0]          den_reg;
    logic [FRACTION_BITS:0] quot_reg, quot_next;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic [NW+1:0]          trial;

    always_comb
    begin
        trial     = {rem_reg, 1'b0} - {2'b00, den_reg};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (!trial[NW+1])
        begin
            rem_next  = trial[NW:0];
            quot_next = {quot_reg[FRACTION_BITS-1:0], 1'b1};
        end
        else
        begin
            rem_next  = {rem_reg[NW-1:0], 1'b0};
            quot_next = {quot_reg[FRACTION_BITS-1:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(FRACTION_BITS))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // First step consumes the integer bit (num/den is 0 or 1).
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            if (num >= den)
            begin
                rem_reg  <= {1'b0, num - den};
                quot_reg <= (FRACTION_BITS + 1)'(1);
            end
            else
            begin
                rem_reg  <= {1'b0, num};
                quot_reg <= '0;
            end
        end
        else if (busy_reg && cnt_reg != CW'(FRACTION_BITS))
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;
endmodule

FILE: src/relative_distance_nearest_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_distance_nearest_lookup
// Table of keyed entries searched for the nearest entry in relative L1 distance.
// ----------------------------------------------------------------------------
// A load is written in the cycle it is accepted and the block is ready again
// at once. A query walks the loaded entries one at a time: a read state fetches
// the entry's keys, then the three or four key terms run one after another
// through a single bit-serial divider, and each quotient is added to the sum;
// a term whose keys are both zero skips the divider and adds nothing. The block
// is not ready while a query runs. The result waits in an output register
// until it is taken; a later result never overwrites a waiting one.
module relative_distance_nearest_lookup #(
    parameter int KEY_WIDTH     = 32,
    parameter int FRACTION_BITS = 16
) (
    input logic      clk,
    input logic      rst_n,
    rdnl_in_if.sink  in_ch,
    rdnl_out_if.source out_ch,
    rdnl_cfg_if.sink cfg
);
    import rdnl_pkg::*;

    localparam int AW = INDEX_WIDTH;
    localparam int CNTW = COUNT_WIDTH;
    localparam int SW = FRACTION_BITS + 3;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_TERM, S_WAIT, S_NEXT, S_PICK, S_FETCH, S_OUT
    } state_t;

    logic signed [KEY_WIDTH-1:0] k1_mem [TABLE_DEPTH];
    logic signed [KEY_WIDTH-1:0] k2_mem [TABLE_DEPTH];
    logic signed [KEY_WIDTH-1:0] k3_mem [TABLE_DEPTH];
    logic signed [KEY_WIDTH-1:0] k4_mem [TABLE_DEPTH];
    logic signed [31:0]          val_mem [TABLE_DEPTH];

    state_t                      state_reg;
    logic [10:0]                 count_reg;
    logic                        use4_reg;
    logic signed [KEY_WIDTH-1:0] q_reg [4];
    logic signed [KEY_WIDTH-1:0] t_reg [4];
    logic signed [31:0]          val_rd_reg;
    logic [AW-1:0]               idx_reg, best_idx_reg;
    logic [CNTW-1:0]             limit_reg;
    logic [1:0]                  key_reg;
    logic [SW-1:0]               sum_reg, best_reg;
    logic                        have_reg;
    logic                        out_valid_reg;
    logic signed [31:0]          out_value_reg;
    logic [AW-1:0]               out_index_reg;
    logic                        out_empty_reg;

    logic                        div_start, div_done;
    logic [KEY_WIDTH:0]          div_num, div_den;
    logic [FRACTION_BITS:0]      div_quot;
    logic signed [KEY_WIDTH:0]   qa, tb, diff;
    logic [KEY_WIDTH:0]          mag_q, mag_t;
    logic [SW-1:0]               sum_final;
    logic                        in_fire;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        qa     = {q_reg[key_reg][KEY_WIDTH-1], q_reg[key_reg]};
        tb     = {t_reg[key_reg][KEY_WIDTH-1], t_reg[key_reg]};
        diff   = qa - tb;
        mag_q  = qa[KEY_WIDTH] ? -qa : qa;
        mag_t  = tb[KEY_WIDTH] ? -tb : tb;
        div_den = mag_q + mag_t;
        div_num = diff[KEY_WIDTH] ? -diff : diff;
        div_start = (state_reg == S_TERM) && (div_den != '0);
        sum_final = sum_reg + SW'(div_quot);
    end

    rdnl_divider #(
        .KEY_WIDTH    (KEY_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quot (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.mode == MODE_LOAD)
        begin
            k1_mem[in_ch.entry_index[AW-1:0]]  <= in_ch.key_first;
            k2_mem[in_ch.entry_index[AW-1:0]]  <= in_ch.key_second;
            k3_mem[in_ch.entry_index[AW-1:0]]  <= in_ch.key_third;
            k4_mem[in_ch.entry_index[AW-1:0]]  <= in_ch.key_fourth;
            val_mem[in_ch.entry_index[AW-1:0]] <= in_ch.entry_value;
        end
        t_reg[0]   <= k1_mem[idx_reg];
        t_reg[1]   <= k2_mem[idx_reg];
        t_reg[2]   <= k3_mem[idx_reg];
        t_reg[3]   <= k4_mem[idx_reg];
        val_rd_reg <= val_mem[best_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            use4_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_index_reg <= '0;
            out_empty_reg <= 1'b0;
            have_reg      <= 1'b0;
            idx_reg       <= '0;
            best_idx_reg  <= '0;
            key_reg       <= '0;
            limit_reg     <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            q_reg         <= '{default: '0};
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_ENTRY_COUNT:    count_reg <= cfg.data;
                    REG_USE_FOURTH_KEY: use4_reg  <= cfg.data[0];
                    default:            ;
                endcase
            end
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && in_ch.mode == MODE_QUERY)
                    begin
                        q_reg[0] <= in_ch.key_first;
                        q_reg[1] <= in_ch.key_second;
                        q_reg[2] <= in_ch.key_third;
                        q_reg[3] <= in_ch.key_fourth;
                        idx_reg  <= '0;
                        have_reg <= 1'b0;
                        best_idx_reg <= '0;
                        limit_reg <= (count_reg > CNTW'(TABLE_DEPTH))
                                   ? CNTW'(TABLE_DEPTH) : count_reg;
                        // An empty table goes straight to the result.
                        if (count_reg == '0)
                            state_reg <= S_FETCH;
                        else
                            state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    key_reg   <= '0;
                    sum_reg   <= '0;
                    state_reg <= S_TERM;
                end
                S_TERM:
                begin
                    state_reg <= div_start ? S_WAIT : S_NEXT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        sum_reg   <= sum_final;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (key_reg == 2'd2 && !use4_reg || key_reg == 2'd3)
                    begin
                        if (!have_reg || sum_reg < best_reg)
                        begin
                            best_reg     <= sum_reg;
                            best_idx_reg <= idx_reg;
                            have_reg     <= 1'b1;
                        end
                        if (CNTW'(idx_reg) + 1'b1 == limit_reg)
                            state_reg <= S_PICK;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                    else
                    begin
                        key_reg   <= key_reg + 1'b1;
                        state_reg <= S_TERM;
                    end
                end
                // Lets val_rd_reg pick up the value read at the final best slot.
                S_PICK:
                begin
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    if (!out_valid_reg)
                    begin
                        out_value_reg <= have_reg ? val_rd_reg : '0;
                        out_index_reg <= have_reg ? best_idx_reg : '0;
                        out_empty_reg <= !have_reg;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.found_value = out_value_reg;
    assign out_ch.found_index = out_index_reg;
    assign out_ch.table_empty = out_empty_reg;
endmodule
